// ===== sv/pcorr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcorr_pkg
// Shared widths, status codes and the request bundle of the serial multiplier
// used by the Pearson correlation block.
// ----------------------------------------------------------------------------
package pcorr_pkg;

  // sample and run sizes
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 13;
  localparam int MAX_LEN  = 4096;

  // accumulator widths
  localparam int SUM_W = 28;
  localparam int SQ_W  = 44;

  // final arithmetic widths
  localparam int VAR_W  = 58;              // signed num / variance terms
  localparam int MAG_W  = 56;              // multiplier operand magnitude
  localparam int PROD_W = 2 * MAG_W;       // full product
  localparam int SQR_W  = MAG_W + 3;       // root remainder
  localparam int CMP_W  = 72;              // shared compare/subtract width
  localparam int Q_W    = 17;              // quotient bits
  localparam int FRAC_W = 15;              // Q1.15 scaling
  localparam int ITER_W = 6;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_OVF   = 2'd2
  } status_t;

  // serial multiplier request
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] op_a;
    logic [MAG_W-1:0] op_b;
  } mul_req_t;

endpackage

// ===== sv/pcorr_mul.sv =====
// ----------------------------------------------------------------------------
// pcorr_mul
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pcorr_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  pcorr_pkg::mul_req_t        req,
  output logic [pcorr_pkg::PROD_W-1:0] prod,
  output logic                       done
);

  logic                            busy;
  logic [pcorr_pkg::ITER_W-1:0]    cnt;
  logic [pcorr_pkg::PROD_W-1:0]    acc;
  logic [pcorr_pkg::PROD_W-1:0]    mcand;
  logic [pcorr_pkg::MAG_W-1:0]     mplier;

  // one partial product per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= {{pcorr_pkg::MAG_W{1'b0}}, req.op_a};
        mplier <= req.op_b;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == pcorr_pkg::ITER_W'(pcorr_pkg::MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// ===== sv/pearson_correlation.sv =====
// ----------------------------------------------------------------------------
// pearson_correlation
// Streaming Pearson correlation of paired signed samples, result in Q1.15.
//
//  channel  dir  payload
//  s_axis   in   tdata {b, a}, tlast = last pair of the run
//  m_axis   out  tdata {pair_count, correlation}, tuser = status
//
// A pair passes through acceptance, then three products from one 16x16
// multiplier and a final add. The last pair of a run also runs seven serial
// multiplies, a 56-step square root and a 17-step divide through one shared
// compare/subtract unit. s_axis_tready is low while a pair or a result is in
// work. A result waits in the output register; the next run is accepted
// meanwhile. Synchronous reset clears the run sums and the output valid.
// ----------------------------------------------------------------------------
module pearson_correlation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] sample_a, [31:16] sample_b
  input  logic        s_axis_tlast,   // last_pair
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] correlation, [28:16] pair_count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  typedef enum logic [3:0] {
    S_IDLE, S_AB, S_AA, S_BB, S_ADD, S_CALC, S_MUL, S_CHK,
    S_SQRT, S_RCHK, S_DIV, S_QFIN, S_DONE
  } state_t;

  state_t state;

  // run accumulators
  logic [pcorr_pkg::CNT_W-1:0]        count;
  logic signed [pcorr_pkg::SUM_W-1:0] sum_first, sum_second;
  logic signed [pcorr_pkg::SQ_W-1:0]  sum_cross, sum_first_sq, sum_second_sq;
  logic                               overflowed;

  // latched pair and product
  logic signed [pcorr_pkg::SAMPLE_W-1:0]   smp_a, smp_b;
  logic                                    smp_last;
  logic signed [2*pcorr_pkg::SAMPLE_W-1:0] pprod;
  logic signed [pcorr_pkg::SAMPLE_W-1:0]   fa, fb;

  // final arithmetic
  logic [2:0]                          op;
  logic signed [pcorr_pkg::VAR_W-1:0]  num, va, vb;
  logic [pcorr_pkg::PROD_W-1:0]        p_sh;
  logic [pcorr_pkg::MAG_W-1:0]         root;
  logic [pcorr_pkg::SQR_W-1:0]         sq_rem;
  logic [pcorr_pkg::CMP_W-1:0]         dv_rem, dv_sh;
  logic [pcorr_pkg::Q_W-1:0]           quot;
  logic [pcorr_pkg::ITER_W-1:0]        iter;
  logic [15:0]                         res_corr;
  pcorr_pkg::status_t                  res_stat;

  // multiplier connection
  pcorr_pkg::mul_req_t                 mreq;
  logic                                mreq_start;
  logic                                mreq_start_next;
  logic [pcorr_pkg::PROD_W-1:0]        mprod;
  logic                                mdone;
  logic                                mneg;
  logic signed [pcorr_pkg::VAR_W-1:0]  sprod;

  // shared compare/subtract
  logic [pcorr_pkg::SQR_W-1:0]  sq_in, sq_trial;
  logic [pcorr_pkg::CMP_W-1:0]  cmp_x, cmp_y, cmp_diff;
  logic                         cmp_ge;

  // magnitudes and quotient finish
  logic [pcorr_pkg::SQ_W-1:0]   mag_cross;
  logic [pcorr_pkg::SUM_W-1:0]  mag_first, mag_second;
  logic [pcorr_pkg::VAR_W-1:0]  mag_num;
  logic [pcorr_pkg::Q_W-1:0]    qc, qneg;

  // output register load
  logic                         out_load;

  pcorr_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .prod (mprod),
    .done (mdone)
  );

  // per-pair product operands
  assign fa = (state == S_BB) ? smp_b : smp_a;
  assign fb = (state == S_AA) ? smp_a : smp_b;

  // operand magnitudes
  always_comb begin
    mag_cross  = sum_cross[pcorr_pkg::SQ_W-1]  ? pcorr_pkg::SQ_W'(-sum_cross)
                                                : pcorr_pkg::SQ_W'(sum_cross);
    mag_first  = sum_first[pcorr_pkg::SUM_W-1] ? pcorr_pkg::SUM_W'(-sum_first)
                                                : pcorr_pkg::SUM_W'(sum_first);
    mag_second = sum_second[pcorr_pkg::SUM_W-1] ? pcorr_pkg::SUM_W'(-sum_second)
                                                 : pcorr_pkg::SUM_W'(sum_second);
    mag_num    = num[pcorr_pkg::VAR_W-1] ? pcorr_pkg::VAR_W'(-num)
                                         : pcorr_pkg::VAR_W'(num);
  end

  // multiply operation table
  always_comb begin
    mreq.start = mreq_start;
    mreq.op_a  = '0;
    mreq.op_b  = '0;
    mneg       = 1'b0;
    case (op)
      3'd0: begin
        mreq.op_a = pcorr_pkg::MAG_W'(count);
        mreq.op_b = pcorr_pkg::MAG_W'(mag_cross);
        mneg      = sum_cross[pcorr_pkg::SQ_W-1];
      end
      3'd1: begin
        mreq.op_a = pcorr_pkg::MAG_W'(mag_first);
        mreq.op_b = pcorr_pkg::MAG_W'(mag_second);
        mneg      = sum_first[pcorr_pkg::SUM_W-1] ^ sum_second[pcorr_pkg::SUM_W-1];
      end
      3'd2: begin
        mreq.op_a = pcorr_pkg::MAG_W'(count);
        mreq.op_b = pcorr_pkg::MAG_W'(sum_first_sq);
      end
      3'd3: begin
        mreq.op_a = pcorr_pkg::MAG_W'(mag_first);
        mreq.op_b = pcorr_pkg::MAG_W'(mag_first);
      end
      3'd4: begin
        mreq.op_a = pcorr_pkg::MAG_W'(count);
        mreq.op_b = pcorr_pkg::MAG_W'(sum_second_sq);
      end
      3'd5: begin
        mreq.op_a = pcorr_pkg::MAG_W'(mag_second);
        mreq.op_b = pcorr_pkg::MAG_W'(mag_second);
      end
      3'd6: begin
        mreq.op_a = pcorr_pkg::MAG_W'(va);
        mreq.op_b = pcorr_pkg::MAG_W'(vb);
      end
      default: begin
        mreq.op_a = '0;
      end
    endcase
    sprod = mneg ? -$signed(mprod[pcorr_pkg::VAR_W-1:0])
                 : $signed(mprod[pcorr_pkg::VAR_W-1:0]);
  end

  // multiplier start request for the next cycle
  always_comb begin
    case (state)
      S_CALC:  mreq_start_next = (count >= pcorr_pkg::CNT_W'(2));
      S_MUL:   mreq_start_next = mdone && (op != 3'd5) && (op != 3'd6);
      S_CHK:   mreq_start_next = !(va[pcorr_pkg::VAR_W-1] || vb[pcorr_pkg::VAR_W-1]);
      default: mreq_start_next = 1'b0;
    endcase
  end

  // shared compare/subtract: root step or divide step
  always_comb begin
    sq_in    = {sq_rem[pcorr_pkg::SQR_W-3:0], p_sh[pcorr_pkg::PROD_W-1 -: 2]};
    sq_trial = {1'b0, root, 2'b01};
    if (state == S_SQRT) begin
      cmp_x = pcorr_pkg::CMP_W'(sq_in);
      cmp_y = pcorr_pkg::CMP_W'(sq_trial);
    end else begin
      cmp_x = dv_rem;
      cmp_y = dv_sh;
    end
    cmp_ge   = (cmp_x >= cmp_y);
    cmp_diff = cmp_x - cmp_y;
  end

  // quotient clamp and sign
  always_comb begin
    qc   = (quot > pcorr_pkg::Q_W'(32768)) ? pcorr_pkg::Q_W'(32768) : quot;
    qneg = pcorr_pkg::Q_W'(0) - qc;
  end

  // result enters the output register once it is free
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      sum_first     <= '0;
      sum_second    <= '0;
      sum_cross     <= '0;
      sum_first_sq  <= '0;
      sum_second_sq <= '0;
      overflowed    <= 1'b0;
      mreq_start    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      op            <= '0;
      iter          <= '0;
    end else begin
      mreq_start <= mreq_start_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            smp_a    <= s_axis_tdata[15:0];
            smp_b    <= s_axis_tdata[31:16];
            smp_last <= s_axis_tlast;
            if (count < pcorr_pkg::CNT_W'(pcorr_pkg::MAX_LEN)) begin
              count      <= count + 1'b1;
              sum_first  <= sum_first + pcorr_pkg::SUM_W'($signed(s_axis_tdata[15:0]));
              sum_second <= sum_second + pcorr_pkg::SUM_W'($signed(s_axis_tdata[31:16]));
              state      <= S_AB;
            end else begin
              overflowed <= 1'b1;
              if (s_axis_tlast) begin
                state <= S_CALC;
              end
            end
          end
        end
        S_AB: begin
          pprod <= fa * fb;
          state <= S_AA;
        end
        S_AA: begin
          sum_cross <= sum_cross + pcorr_pkg::SQ_W'(pprod);
          pprod     <= fa * fb;
          state     <= S_BB;
        end
        S_BB: begin
          sum_first_sq <= sum_first_sq + pcorr_pkg::SQ_W'(pprod);
          pprod        <= fa * fb;
          state        <= S_ADD;
        end
        S_ADD: begin
          sum_second_sq <= sum_second_sq + pcorr_pkg::SQ_W'(pprod);
          state         <= smp_last ? S_CALC : S_IDLE;
        end
        S_CALC: begin
          if (count < pcorr_pkg::CNT_W'(2)) begin
            res_corr <= '0;
            res_stat <= pcorr_pkg::STAT_SHORT;
            state    <= S_DONE;
          end else begin
            op    <= 3'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mdone) begin
            case (op)
              3'd0: num <= sprod;
              3'd1: num <= num - sprod;
              3'd2: va  <= sprod;
              3'd3: va  <= va - sprod;
              3'd4: vb  <= sprod;
              3'd5: vb  <= vb - sprod;
              default: begin
                p_sh   <= mprod;
                root   <= '0;
                sq_rem <= '0;
              end
            endcase
            iter <= '0;
            if (op == 3'd5) begin
              state <= S_CHK;
            end else if (op == 3'd6) begin
              state <= S_SQRT;
            end else begin
              op <= op + 1'b1;
            end
          end
        end
        S_CHK: begin
          // a negative variance counts as zero variance
          if (va[pcorr_pkg::VAR_W-1] || vb[pcorr_pkg::VAR_W-1]) begin
            res_corr <= '0;
            res_stat <= pcorr_pkg::STAT_SHORT;
            state    <= S_DONE;
          end else begin
            op    <= 3'd6;
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          if (cmp_ge) begin
            sq_rem <= cmp_diff[pcorr_pkg::SQR_W-1:0];
            root   <= {root[pcorr_pkg::MAG_W-2:0], 1'b1};
          end else begin
            sq_rem <= sq_in;
            root   <= {root[pcorr_pkg::MAG_W-2:0], 1'b0};
          end
          p_sh <= p_sh << 2;
          iter <= iter + 1'b1;
          if (iter == pcorr_pkg::ITER_W'(pcorr_pkg::MAG_W - 1)) begin
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          if (root == '0) begin
            res_corr <= '0;
            res_stat <= pcorr_pkg::STAT_SHORT;
            state    <= S_DONE;
          end else begin
            dv_rem <= {mag_num[pcorr_pkg::CMP_W-pcorr_pkg::FRAC_W-1:0],
                       {pcorr_pkg::FRAC_W{1'b0}}};
            dv_sh  <= pcorr_pkg::CMP_W'({root, {(pcorr_pkg::Q_W-1){1'b0}}});
            quot   <= '0;
            iter   <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (cmp_ge) begin
            dv_rem <= cmp_diff;
          end
          quot  <= {quot[pcorr_pkg::Q_W-2:0], cmp_ge};
          dv_sh <= dv_sh >> 1;
          iter  <= iter + 1'b1;
          if (iter == pcorr_pkg::ITER_W'(pcorr_pkg::Q_W - 1)) begin
            state <= S_QFIN;
          end
        end
        S_QFIN: begin
          if (num[pcorr_pkg::VAR_W-1]) begin
            res_corr <= qneg[15:0];
          end else if (qc > pcorr_pkg::Q_W'(32767)) begin
            res_corr <= 16'h7fff;
          end else begin
            res_corr <= qc[15:0];
          end
          res_stat <= pcorr_pkg::STAT_OK;
          state    <= S_DONE;
        end
        S_DONE: begin
          // hand over once the output register is free, then clear the run
          if (out_load) begin
            m_axis_tdata  <= {3'b000, count, res_corr};
            m_axis_tuser  <= overflowed ? pcorr_pkg::STAT_OVF : res_stat;
            count         <= '0;
            sum_first     <= '0;
            sum_second    <= '0;
            sum_cross     <= '0;
            sum_first_sq  <= '0;
            sum_second_sq <= '0;
            overflowed    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);

endmodule

// ===== sv/pcorr_chk.sv =====
// ----------------------------------------------------------------------------
// pcorr_chk
// Port-level checks of the correlation block's results.
// ----------------------------------------------------------------------------
module pcorr_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // status is one of the three defined codes
  a_stat_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == pcorr_pkg::STAT_OK ||
                       m_axis_tuser == pcorr_pkg::STAT_SHORT ||
                       m_axis_tuser == pcorr_pkg::STAT_OVF))
    else $error("bad status code");

  // pair count never passes the run limit
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[28:16] <= 13'(pcorr_pkg::MAX_LEN)))
    else $error("pair count above limit");

  // a good result needs two pairs
  a_ok_two: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == pcorr_pkg::STAT_OK) |->
      (m_axis_tdata[28:16] >= 13'd2))
    else $error("ok status with under two pairs");

  // short run or flat series reads zero
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == pcorr_pkg::STAT_SHORT) |->
      (m_axis_tdata[15:0] == 16'd0))
    else $error("nonzero correlation on short status");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind pearson_correlation pcorr_chk u_pcorr_chk (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pearson_correlation. Runs of sample pairs are
// streamed in, the random runs with random gaps. A scoreboard tracks the
// running sums in 64-bit wrapping arithmetic and computes the expected Q1.15
// coefficient, status and pair count for every terminating pair. The output
// side stalls at random, and once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct {
    logic [15:0]           corr;
    pcorr_pkg::status_t    stat;
    logic [12:0]           cnt;
  } corr_result_t;

  // running sums and the queue of predicted results
  class corr_scoreboard;
    logic [63:0]  n, s_a, s_b, s_ab, s_aa, s_bb;
    bit           ovf;
    corr_result_t pending_q[$];
    int           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      n = 0; s_a = 0; s_b = 0; s_ab = 0; s_aa = 0; s_bb = 0; ovf = 0;
    endfunction

    function logic [63:0] root_floor(logic [127:0] p);
      logic [63:0]  r;
      logic [63:0]  cand;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        cand = r | (64'd1 << i);
        if ({64'd0, cand} * {64'd0, cand} <= p) r = cand;
      end
      return r;
    endfunction

    // note one accepted pair
    function void note_pair(logic [15:0] a, logic [15:0] b, bit last);
      logic [63:0]  ax, bx, num, va, vb, d, mag;
      logic [127:0] q;
      corr_result_t res;
      ax = {{48{a[15]}}, a};
      bx = {{48{b[15]}}, b};
      if (n < pcorr_pkg::MAX_LEN) begin
        n++;
        s_a += ax; s_b += bx;
        s_ab += ax * bx; s_aa += ax * ax; s_bb += bx * bx;
      end else begin
        ovf = 1;
      end
      if (!last) return;
      res.corr = 0;
      res.stat = pcorr_pkg::STAT_OK;
      if (n < 2) begin
        res.stat = pcorr_pkg::STAT_SHORT;
      end else begin
        num = n * s_ab - s_a * s_b;
        va = n * s_aa - s_a * s_a;
        vb = n * s_bb - s_b * s_b;
        d = 0;
        if (!va[63] && !vb[63]) d = root_floor({64'd0, va} * {64'd0, vb});
        if (d == 0) begin
          res.stat = pcorr_pkg::STAT_SHORT;
        end else begin
          mag = num[63] ? -num : num;
          q = ({64'd0, mag} << 15) / {64'd0, d};
          if (q > 32768) q = 32768;
          if (num[63]) res.corr = -q[15:0];
          else res.corr = (q > 32767) ? 16'd32767 : q[15:0];
        end
      end
      if (ovf) res.stat = pcorr_pkg::STAT_OVF;
      res.cnt = n[12:0];
      pending_q.push_back(res);
      clear();
    endfunction

    // compare one delivered result against the oldest prediction
    function void check_result(logic [15:0] corr, logic [1:0] stat, logic [12:0] cnt);
      corr_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result corr=%0d status=%0d count=%0d", $signed(corr), stat, cnt);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (corr !== e.corr) begin
        $error("correlation: expected %0d, got %0d", $signed(e.corr), $signed(corr));
        errors++;
      end
      if (stat !== e.stat) begin
        $error("status: expected %0d, got %0d", e.stat, stat);
        errors++;
      end
      if (cnt !== e.cnt) begin
        $error("pair_count: expected %0d, got %0d", e.cnt, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  corr_scoreboard sb;
  bit hold_req;
  int idle_cycles;

  pearson_correlation DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // offer one pair and wait for its transfer
  task automatic send_pair(logic [15:0] a, logic [15:0] b, bit last, bit gaps);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pair(a, b, last);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one run with a chosen content style
  task automatic send_run(int len, int style, bit gaps);
    logic [15:0] a, b;
    logic [15:0] k;
    k = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      case (style)
        0: b = 16'($urandom);
        1: b = a + 16'($urandom_range(0, 15)) - 16'd7;
        2: b = -a;
        3: begin a = k; b = 16'($urandom); end
        4: begin
          a = 16'($urandom_range(0, 15)) - 16'd8;
          b = 16'($urandom_range(0, 15)) - 16'd8;
        end
        5: begin a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; b = a; end
        default: b = a;
      endcase
      send_pair(a, b, i == len - 1, gaps);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        hold = 0;
        while (hold < 3000) begin
          @(posedge clk);
          hold++;
        end
        hold_req = 0;
      end else if ($urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[28:16]);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int items;
    int len;
    bit held;
    sb = new();
    hold_req = 0;
    held = 0;
    idle_cycles = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single pair, two pairs, extremes, perfect +/- correlation
    send_pair(16'h7fff, 16'h8000, 1, 0);
    send_pair(16'h0001, 16'h0002, 0, 0);
    send_pair(16'h0003, 16'h0005, 1, 0);
    send_pair(16'h8000, 16'h8000, 0, 0);
    send_pair(16'h7fff, 16'h7fff, 0, 0);
    send_pair(16'h0000, 16'h0000, 1, 0);
    send_pair(16'h8000, 16'h7fff, 0, 0);
    send_pair(16'h7fff, 16'h8001, 0, 0);
    send_pair(16'h0000, 16'h0000, 1, 0);
    // zero variance: constant first series
    send_pair(16'h1234, 16'h0001, 0, 0);
    send_pair(16'h1234, 16'hffff, 0, 0);
    send_pair(16'h1234, 16'h8000, 1, 0);
    send_pair(16'h0000, 16'h0000, 0, 0);
    send_pair(16'h0000, 16'h0000, 1, 0);
    send_run(6, 0, 0);
    wait_drained();

    // full-scale run past the length limit
    send_run(pcorr_pkg::MAX_LEN + 5, 5, 0);
    wait_drained();

    // random runs; long output hold-off partway through
    items = 0;
    while (items < 1500) begin
      if (items > 300 && !held) begin
        hold_req = 1;
        held = 1;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
      send_run(len, $urandom_range(0, 6), 1);
      items += len;
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
